[design/vatt_pkg.sv]
// package for the tlb translator: payload structs, constants, helpers
// no dependencies
package vatt_pkg;

    localparam int TLB_ENTRIES = 64;

    localparam logic [1:0] FUNC_XLATE = 2'd0;
    localparam logic [1:0] FUNC_CREAD = 2'd1;
    localparam logic [1:0] FUNC_CWRITE = 2'd2;

    localparam logic [1:0] CFG_RAM_BASE = 2'd0;
    localparam logic [1:0] CFG_RAM_MASK = 2'd1;
    localparam logic [1:0] CFG_VRAM_BASE = 2'd2;
    localparam logic [1:0] CFG_VRAM_SIZE = 2'd3;

    localparam logic [31:0] CTRL_ADDR = 32'hFF000010;
    localparam logic [31:0] PPN_MASK = 32'h1FFFFC00;
    localparam logic [28:0] RAM_BASE_RST = 29'h0C000000;
    localparam logic [28:0] RAM_MASK_RST = 29'h00FFFFFF;
    localparam logic [28:0] VRAM_BASE_RST = 29'h04000000;
    localparam logic [28:0] VRAM_SIZE_RST = 29'h00800000;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FIN, ST_OUT} t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [31:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [31:0] xlat_addr;
        logic [31:0] read_data;
        logic        tlb_hit;
    } t_out_word;

    // per-cell control broadcast to every cell of the chain
    typedef struct packed {
        logic        wr_tag;
        logic        wr_data;
        logic        clr_valid;
        logic [5:0]  index;
        logic [31:0] wdata;
    } t_cell_ctl;

    // lookup word travelling along the chain
    typedef struct packed {
        logic        live;
        logic        found;
        logic [31:0] addr;
        logic [31:0] phys;
        logic [31:0] rdata;
    } t_probe;

    function automatic logic [31:0] entry_size_mask(input logic [31:0] d);
        case ({d[7], d[4]})
            2'b00:   entry_size_mask = 32'hFFFFFC00;
            2'b01:   entry_size_mask = 32'hFFFFF000;
            2'b10:   entry_size_mask = 32'hFFFF0000;
            default: entry_size_mask = 32'hFFF00000;
        endcase
    endfunction

endpackage

[design/vatt_cell.sv]
// one tlb entry cell: holds tag and data, matches the probe handed in
// depends on vatt_pkg
module vatt_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vatt_pkg::t_cell_ctl i_ctl,
    input  vatt_pkg::t_probe   i_probe,
    input  logic               i_rd_tag,
    input  logic               i_rd_data,
    output vatt_pkg::t_probe   o_probe
);
    logic [31:0] r_tag;
    logic [31:0] r_data;
    logic [31:0] w_mask;
    logic        w_sel;
    vatt_pkg::t_probe n_probe;

    assign w_sel  = (i_ctl.index == 6'(IDX));
    assign w_mask = vatt_pkg::entry_size_mask(r_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag  <= '0;
            r_data <= '0;
        end else begin
            if (i_ctl.wr_tag && w_sel) begin
                r_tag <= i_ctl.wdata;
            end else if (i_ctl.clr_valid) begin
                r_tag[8] <= 1'b0;
            end
            if (i_ctl.wr_data && w_sel) begin
                r_data <= i_ctl.wdata;
            end
        end
    end

    always_comb begin
        n_probe = i_probe;
        if (i_probe.live && !i_probe.found && r_tag[8]
                && ((i_probe.addr & w_mask) == (r_tag & w_mask))) begin
            n_probe.found = 1'b1;
            n_probe.phys  = (r_data & vatt_pkg::PPN_MASK) | (i_probe.addr & ~w_mask);
        end
        if (w_sel && i_rd_tag) begin
            n_probe.rdata = r_tag;
        end
        if (w_sel && i_rd_data) begin
            n_probe.rdata = r_data;
        end
    end

    assign o_probe = n_probe;
endmodule

[design/vatt_chain.sv]
// chain of tlb cells; the probe walks one cell per cycle
// depends on vatt_pkg, vatt_cell
module vatt_chain #(
    parameter int N = vatt_pkg::TLB_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vatt_pkg::t_cell_ctl i_ctl,
    input  vatt_pkg::t_probe    i_probe,
    input  logic                i_start,
    input  logic                i_rd_tag,
    input  logic                i_rd_data,
    output vatt_pkg::t_probe    o_probe,
    output logic                o_done
);
    localparam int CW = $clog2(N);
    vatt_pkg::t_probe w_out [N];
    vatt_pkg::t_probe r_probe;
    logic [CW-1:0] r_pos;
    logic          r_busy;
    logic          r_rtag;
    logic          r_rdat;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            vatt_cell #(.IDX(g)) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (i_ctl),
                .i_probe   (r_probe),
                .i_rd_tag  (r_rtag && r_busy && r_pos == CW'(g)),
                .i_rd_data (r_rdat && r_busy && r_pos == CW'(g)),
                .o_probe   (w_out[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (r_busy) begin
            if (r_pos == CW'(N - 1)) begin
                r_busy <= 1'b0;
            end
            r_pos <= r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_probe <= i_probe;
            r_rtag  <= i_rd_tag;
            r_rdat  <= i_rd_data;
        end else if (r_busy) begin
            r_probe <= w_out[r_pos];
        end
    end

    assign o_probe = r_probe;
    assign o_done  = !r_busy;
endmodule

[design/virtual_address_tlb_translator.sv]
// top level: tlb translator with region decode, fold heuristic and control space
// depends on vatt_pkg, vatt_chain
//
// channel  dir  handshake       word
// in       in   valid / stall   t_in_word
// out      out  valid / stall   t_out_word
// cfg      in   valid / ready   index, data
//
// a word is accepted only when idle; it then passes the walk and fin states, and its result
// is registered and held valid in the out state; the next word is not accepted until that result has left the output
// control writes and direct mappings use the same walk, so every item goes through it
// reset is synchronous; all tag valid bits and mmu control clear on reset
// the input stalls while an item is in flight or a result waits on the output
module virtual_address_tlb_translator #(
    parameter int TLB_ENTRIES = vatt_pkg::TLB_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vatt_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vatt_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    vatt_pkg::t_state r_state, n_state;
    vatt_pkg::t_in_word  r_in;
    vatt_pkg::t_out_word r_out;
    logic [28:0] r_ram_base, r_ram_mask, r_vram_base, r_vram_size;
    logic [31:0] r_ctrl;
    logic        w_acc, w_start, w_done;
    logic        w_tag, w_data, w_ent_ok, w_tlb;
    vatt_pkg::t_cell_ctl w_ctl;
    vatt_pkg::t_probe    w_probe_in, w_probe_out;
    logic [28:0] w_low;
    logic [29:0] w_vend, w_rend;
    logic        w_inmem;
    logic [31:0] w_fold, w_heur;
    vatt_pkg::t_out_word n_out;

    assign w_acc  = i_in_valid && !o_in_stall;
    assign w_tag  = r_in.address[31:24] == 8'hF6;
    assign w_data = r_in.address[31:23] == 9'h1EE;
    assign w_ent_ok = 32'(r_in.address[13:8]) < 32'(TLB_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vatt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        case (r_state)
            vatt_pkg::ST_IDLE: begin
                if (w_acc) n_state = vatt_pkg::ST_WALK;
            end
            vatt_pkg::ST_WALK: begin
                w_start = 1'b1;
                n_state = vatt_pkg::ST_FIN;
            end
            vatt_pkg::ST_FIN: begin
                if (w_done) n_state = vatt_pkg::ST_OUT;
            end
            vatt_pkg::ST_OUT: begin
                if (!i_out_stall) n_state = vatt_pkg::ST_IDLE;
            end
            default: n_state = vatt_pkg::ST_IDLE;
        endcase
    end

    assign o_in_stall  = r_state != vatt_pkg::ST_IDLE;
    assign o_out_valid = r_state == vatt_pkg::ST_OUT;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_acc) r_in <= i_in_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_base  <= vatt_pkg::RAM_BASE_RST;
            r_ram_mask  <= vatt_pkg::RAM_MASK_RST;
            r_vram_base <= vatt_pkg::VRAM_BASE_RST;
            r_vram_size <= vatt_pkg::VRAM_SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vatt_pkg::CFG_RAM_BASE:  r_ram_base  <= i_cfg_data[28:0];
                vatt_pkg::CFG_RAM_MASK:  r_ram_mask  <= i_cfg_data[28:0];
                vatt_pkg::CFG_VRAM_BASE: r_vram_base <= i_cfg_data[28:0];
                default:                 r_vram_size <= i_cfg_data[28:0];
            endcase
        end
    end

    // control write happens at walk start
    always_comb begin
        w_ctl = '0;
        w_ctl.index = r_in.address[13:8];
        w_ctl.wdata = r_in.write_data;
        if (w_start && r_in.func == vatt_pkg::FUNC_CWRITE && w_ent_ok) begin
            w_ctl.wr_tag  = w_tag;
            w_ctl.wr_data = w_data;
        end
        w_ctl.clr_valid = w_start && r_in.func == vatt_pkg::FUNC_CWRITE
            && r_in.address == vatt_pkg::CTRL_ADDR && r_in.write_data[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (w_ctl.clr_valid) begin
            r_ctrl <= r_in.write_data & ~32'h4;
        end else if (w_start && r_in.func == vatt_pkg::FUNC_CWRITE
                && r_in.address == vatt_pkg::CTRL_ADDR) begin
            r_ctrl <= r_in.write_data;
        end
    end

    assign w_tlb = r_in.address < 32'h80000000 || r_in.address[31:29] == 3'b110;

    always_comb begin
        w_probe_in       = '0;
        w_probe_in.live  = r_in.func == vatt_pkg::FUNC_XLATE && w_tlb && r_ctrl[0];
        w_probe_in.addr  = r_in.address;
    end

    vatt_chain #(.N(TLB_ENTRIES)) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_probe   (w_probe_in),
        .i_start   (w_start),
        .i_rd_tag  (r_in.func == vatt_pkg::FUNC_CREAD && w_tag && w_ent_ok),
        .i_rd_data (r_in.func == vatt_pkg::FUNC_CREAD && w_data && !w_tag && w_ent_ok),
        .o_probe   (w_probe_out),
        .o_done    (w_done)
    );

    // fold heuristic
    assign w_low  = r_in.address[28:0];
    assign w_vend = 30'(r_vram_base) + 30'(r_vram_size);
    assign w_rend = 30'(r_ram_base) + 30'(r_ram_mask) + 30'd1;
    assign w_inmem = (w_low < 29'h1000000)
        || (30'(w_low) >= 30'(r_vram_base) && 30'(w_low) < w_vend)
        || (w_low >= 29'h5000000 && w_low < 29'h5800000)
        || (30'(w_low) >= 30'(r_ram_base) && 30'(w_low) < w_rend);
    assign w_fold = 32'(r_ram_base) + 32'(r_in.address[28:0] & r_ram_mask);
    assign w_heur = w_inmem ? 32'(w_low) : w_fold;

    always_comb begin
        n_out = '0;
        case (r_in.func)
            vatt_pkg::FUNC_XLATE: begin
                if (r_in.address[31:29] == 3'b101) begin
                    n_out.xlat_addr = 32'(w_low);
                end else if (r_in.address[31:29] == 3'b111) begin
                    n_out.xlat_addr = '1;
                end else if (w_probe_out.found) begin
                    n_out.xlat_addr = w_probe_out.phys;
                    n_out.tlb_hit   = 1'b1;
                end else begin
                    n_out.xlat_addr = w_heur;
                end
            end
            vatt_pkg::FUNC_CREAD: begin
                if (r_in.address == vatt_pkg::CTRL_ADDR) begin
                    n_out.read_data = r_ctrl;
                end else begin
                    n_out.read_data = w_probe_out.rdata;
                end
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == vatt_pkg::ST_FIN && w_done) r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_hit_xlate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.tlb_hit |-> r_in.func == vatt_pkg::FUNC_XLATE)
        else $error("tlb hit on non-translate word");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result lost under stall");
    a_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != vatt_pkg::ST_IDLE |-> !w_acc)
        else $error("word accepted while busy");
`endif
endmodule

[sim/vatt_checker.sv]
// checker for the tlb translator: watches the in, out and cfg channels,
// predicts each result word and compares it with the block's output
// depends on vatt_pkg
`timescale 1ns / 100ps
module vatt_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  vatt_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  vatt_pkg::t_out_word i_out_word,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    logic [28:0] ram_base, ram_mask, vram_base, vram_size;
    logic [31:0] tags [vatt_pkg::TLB_ENTRIES];
    logic [31:0] datas [vatt_pkg::TLB_ENTRIES];
    logic [31:0] mmu_ctl;
    vatt_pkg::t_out_word expected_words [$];

    function automatic logic in_region(input logic [31:0] p);
        logic [32:0] q;
        q = {1'b0, p};
        in_region = (q < 33'h01000000)
            || (q >= vram_base && q < {4'd0, vram_base} + vram_size)
            || (q >= 33'h05000000 && q < 33'h05800000)
            || (q >= ram_base && q < {4'd0, ram_base} + ram_mask + 33'd1);
    endfunction

    function automatic logic [31:0] fold_addr(input logic [31:0] a);
        logic [31:0] p;
        p = a & 32'h1FFFFFFF;
        if (in_region(p)) fold_addr = p;
        else fold_addr = {3'd0, ram_base} + (a & {3'd0, ram_mask});
    endfunction

    function automatic vatt_pkg::t_out_word translate_word(input logic [31:0] a);
        vatt_pkg::t_out_word r;
        logic [31:0] m;
        r = '0;
        if (a >= 32'hA0000000 && a < 32'hC0000000) r.xlat_addr = a & 32'h1FFFFFFF;
        else if (a >= 32'h80000000 && a < 32'hA0000000) r.xlat_addr = fold_addr(a);
        else if (a >= 32'hE0000000) r.xlat_addr = '1;
        else begin
            r.xlat_addr = fold_addr(a);
            if (mmu_ctl[0]) begin
                for (int i = 0; i < vatt_pkg::TLB_ENTRIES; i++) begin
                    m = vatt_pkg::entry_size_mask(datas[i]);
                    if (!r.tlb_hit && tags[i][8] && (a & m) == (tags[i] & m)) begin
                        r.tlb_hit = 1'b1;
                        r.xlat_addr = (datas[i] & vatt_pkg::PPN_MASK) | (a & ~m);
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic vatt_pkg::t_out_word apply_word(input vatt_pkg::t_in_word w);
        vatt_pkg::t_out_word r;
        int e;
        logic is_tag, is_data;
        r = '0;
        e = (w.address >> 8) & 63;
        is_tag = w.address >= 32'hF6000000 && w.address < 32'hF7000000;
        is_data = w.address >= 32'hF7000000 && w.address < 32'hF7800000;
        if (w.func == vatt_pkg::FUNC_XLATE) r = translate_word(w.address);
        else if (w.func == vatt_pkg::FUNC_CREAD) begin
            if (w.address == vatt_pkg::CTRL_ADDR) r.read_data = mmu_ctl;
            else if (is_tag && e < vatt_pkg::TLB_ENTRIES) r.read_data = tags[e];
            else if (is_data && e < vatt_pkg::TLB_ENTRIES) r.read_data = datas[e];
        end else if (w.func == vatt_pkg::FUNC_CWRITE) begin
            if (w.address == vatt_pkg::CTRL_ADDR) begin
                mmu_ctl = w.write_data;
                if (w.write_data[2]) begin
                    for (int i = 0; i < vatt_pkg::TLB_ENTRIES; i++) tags[i][8] = 1'b0;
                    mmu_ctl[2] = 1'b0;
                end
            end else if (is_tag && e < vatt_pkg::TLB_ENTRIES) tags[e] = w.write_data;
            else if (is_data && e < vatt_pkg::TLB_ENTRIES) datas[e] = w.write_data;
        end
        return r;
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        vatt_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            ram_base = vatt_pkg::RAM_BASE_RST;
            ram_mask = vatt_pkg::RAM_MASK_RST;
            vram_base = vatt_pkg::VRAM_BASE_RST;
            vram_size = vatt_pkg::VRAM_SIZE_RST;
            for (int i = 0; i < vatt_pkg::TLB_ENTRIES; i++) begin
                tags[i] = '0;
                datas[i] = '0;
            end
            mmu_ctl = '0;
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_out_word);
                    o_fail_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.xlat_addr !== i_out_word.xlat_addr
                        || exp_w.read_data !== i_out_word.read_data
                        || exp_w.tlb_hit !== i_out_word.tlb_hit) begin
                        $display("%0t: mismatch expected %h/%h/%b actual %h/%h/%b", $time,
                            exp_w.xlat_addr, exp_w.read_data, exp_w.tlb_hit,
                            i_out_word.xlat_addr, i_out_word.read_data, i_out_word.tlb_hit);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    vatt_pkg::CFG_RAM_BASE:  ram_base = i_cfg_data[28:0];
                    vatt_pkg::CFG_RAM_MASK:  ram_mask = i_cfg_data[28:0];
                    vatt_pkg::CFG_VRAM_BASE: vram_base = i_cfg_data[28:0];
                    default:                 vram_size = i_cfg_data[28:0];
                endcase
            end
            if (i_in_valid && !i_in_stall) expected_words.push_back(apply_word(i_in_word));
        end
    end
endmodule

[sim/virtual_address_tlb_translator_tb.sv]
// testbench top for the tlb translator: clock, reset, stimulus and verdict
// depends on vatt_pkg, vatt_checker and the block
`timescale 1ns / 100ps
module virtual_address_tlb_translator_tb;
    localparam int LATENCY = vatt_pkg::TLB_ENTRIES + 8;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk, i_rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    vatt_pkg::t_in_word in_word;
    vatt_pkg::t_out_word out_word;
    int fail_count, pending, idle_cycles;
    logic hold_long, stim_done;

    virtual_address_tlb_translator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    vatt_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        out_stall = 1'b0;
        hold_long = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long) out_stall <= 1'b1;
            else if (($time / 4000) % 3 == 0) out_stall <= 1'b0;
            else out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("virtual_address_tlb_translator test failed");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] f, input logic [31:0] a, input logic [31:0] d);
        in_valid <= 1'b1;
        in_word <= '{func: f, address: a, write_data: d};
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        if ($urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_vaddr();
        case ($urandom_range(0, 5))
            0: return {3'b101, 29'($urandom)};
            1: return {3'b100, 29'($urandom)};
            2: return {3'b111, 29'($urandom)};
            3: return {$urandom_range(0, 3) == 0 ? 3'b110 : 3'b000, 29'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_tlb();
        logic [31:0] va;
        for (int i = 0; i < 12; i++) begin
            va = {$urandom_range(0, 7) == 0 ? 3'b110 : 3'b000, 29'($urandom)};
            send_word(vatt_pkg::FUNC_CWRITE, 32'hF6000000 | ($urandom_range(0, 63) << 8),
                (va & 32'hFFFFFC00) | ($urandom_range(0, 3) == 0 ? 32'h0 : 32'h100)
                | ($urandom & 32'hFF));
            send_word(vatt_pkg::FUNC_CWRITE, 32'hF7000000 | ($urandom_range(0, 63) << 8),
                $urandom);
        end
    endtask

    task automatic run_random(input int n);
        logic [31:0] tag_probe;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0, 1: send_word(vatt_pkg::FUNC_CWRITE,
                    32'hF6000000 | ($urandom_range(0, 63) << 8) | ($urandom & 32'hFF),
                    $urandom);
                2, 3: send_word(vatt_pkg::FUNC_CWRITE,
                    32'hF7000000 | ($urandom_range(0, 63) << 8) | ($urandom & 32'hFF),
                    $urandom);
                4: send_word(vatt_pkg::FUNC_CWRITE, vatt_pkg::CTRL_ADDR, $urandom | 32'h1);
                5: send_word(vatt_pkg::FUNC_CREAD, vatt_pkg::CTRL_ADDR, $urandom);
                6: send_word(vatt_pkg::FUNC_CREAD, 32'hF6000000 | ($urandom & 32'hFFFFFF),
                    $urandom);
                7: send_word(vatt_pkg::FUNC_CREAD, 32'hF7000000 | ($urandom & 32'h7FFFFF),
                    $urandom);
                8: send_word(2'($urandom), $urandom, $urandom);
                9: send_word(2'd3, rand_vaddr(), $urandom);
                default: begin
                    tag_probe = {$urandom_range(0, 3) == 0 ? 3'b110 : 3'b000, 29'($urandom)};
                    send_word(vatt_pkg::FUNC_XLATE,
                        $urandom_range(0, 1) ? tag_probe : rand_vaddr(), $urandom);
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_index = vatt_pkg::CFG_RAM_BASE;
        cfg_data = '0;
        stim_done = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: regions, control space, overlapping entries, edge codes
        send_word(vatt_pkg::FUNC_XLATE, 32'h00000000, 32'h0);
        send_word(vatt_pkg::FUNC_XLATE, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_word(vatt_pkg::FUNC_XLATE, 32'hA0000000, 32'h0);
        send_word(vatt_pkg::FUNC_XLATE, 32'hBFFFFFFF, 32'h0);
        send_word(vatt_pkg::FUNC_XLATE, 32'h8C001234, 32'h0);
        send_word(vatt_pkg::FUNC_XLATE, 32'h9FFFFFFF, 32'h0);
        send_word(vatt_pkg::FUNC_XLATE, 32'hE0000000, 32'h0);
        send_word(vatt_pkg::FUNC_CWRITE, 32'hF6000000, 32'h12345100);
        send_word(vatt_pkg::FUNC_CWRITE, 32'hF7000000, 32'h0ABCD090);
        send_word(vatt_pkg::FUNC_CWRITE, 32'hF6000100, 32'h12345100);
        send_word(vatt_pkg::FUNC_CWRITE, 32'hF7000100, 32'h01111000);
        send_word(vatt_pkg::FUNC_CWRITE, 32'hF6003F00, 32'hFFFFFFFF);
        send_word(vatt_pkg::FUNC_CWRITE, vatt_pkg::CTRL_ADDR, 32'h00000001);
        send_word(vatt_pkg::FUNC_XLATE, 32'h12345678, 32'h0);
        send_word(vatt_pkg::FUNC_XLATE, 32'hDFFFFFFF, 32'h0);
        send_word(vatt_pkg::FUNC_CREAD, 32'hF6000000, 32'h0);
        send_word(vatt_pkg::FUNC_CREAD, 32'hF7003FFF, 32'h0);
        send_word(vatt_pkg::FUNC_CREAD, vatt_pkg::CTRL_ADDR, 32'h0);
        send_word(vatt_pkg::FUNC_CREAD, 32'hF7800000, 32'h0);
        send_word(vatt_pkg::FUNC_CWRITE, 32'hF7800100, 32'hFFFFFFFF);
        send_word(2'd3, 32'h12345678, 32'hFFFFFFFF);
        send_word(vatt_pkg::FUNC_CWRITE, vatt_pkg::CTRL_ADDR, 32'hFFFFFFFF);
        send_word(vatt_pkg::FUNC_CREAD, vatt_pkg::CTRL_ADDR, 32'h0);
        send_word(vatt_pkg::FUNC_XLATE, 32'h12345678, 32'h0);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_long = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_long = 1'b0;
            end
            begin
                fill_tlb();
            end
        join

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(vatt_pkg::CFG_RAM_BASE, 32'h0);
                    write_reg(vatt_pkg::CFG_RAM_MASK, 32'h1FFFFFFF);
                    write_reg(vatt_pkg::CFG_VRAM_BASE, 32'h1FFFFFFF);
                    write_reg(vatt_pkg::CFG_VRAM_SIZE, 32'h1FFFFFFF);
                end
                1: begin
                    write_reg(vatt_pkg::CFG_RAM_BASE, 32'h1FFFFFFF);
                    write_reg(vatt_pkg::CFG_RAM_MASK, 32'h0);
                    write_reg(vatt_pkg::CFG_VRAM_BASE, 32'h0);
                    write_reg(vatt_pkg::CFG_VRAM_SIZE, 32'h0);
                end
                default: begin
                    write_reg(vatt_pkg::CFG_RAM_BASE, $urandom);
                    write_reg(vatt_pkg::CFG_RAM_MASK, $urandom >> $urandom_range(3, 31));
                    write_reg(vatt_pkg::CFG_VRAM_BASE, $urandom);
                    write_reg(vatt_pkg::CFG_VRAM_SIZE, $urandom >> $urandom_range(3, 31));
                end
            endcase
            fill_tlb();
            send_word(vatt_pkg::FUNC_CWRITE, vatt_pkg::CTRL_ADDR, 32'h1);
            run_random(300);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
        if (fail_count == 0) $display("virtual_address_tlb_translator test passed");
        else $display("virtual_address_tlb_translator test failed");
        $finish;
    end
endmodule
